>>> rtl/bwvp_pkg.sv
// Package for the binned weighted velocity profile core.
// Holds the transaction payload structs, item kind codes and shared constants.
// No dependencies.
package bwvp_pkg;

   typedef enum logic [1:0] {
      KIND_FRAME   = 2'd0,
      KIND_SAMPLE  = 2'd1,
      KIND_READOUT = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   localparam logic [1:0] CSR_SLICE_COUNT = 2'd0;
   localparam logic [1:0] CSR_CENTER_MODE = 2'd1;
   localparam logic [1:0] CSR_WEIGHT_MASS = 2'd2;

   localparam logic [8:0]  SLICE_COUNT_RESET = 9'd100;
   localparam logic [30:0] HEIGHT_RESET      = 31'd65536;
   localparam logic [31:0] ONE_Q16           = 32'd65536;

   typedef struct packed {
      logic [1:0]         kind;
      logic [1:0]         group;
      logic signed [31:0] position;
      logic signed [31:0] velocity;
      logic [31:0]        weight;
      logic [30:0]        box_height;
      logic [7:0]         bin_select;
   } req_type;

   typedef struct packed {
      logic [1:0]         out_group;
      logic [7:0]         out_slice;
      logic signed [31:0] mean_velocity;
      logic [47:0]        total_weight;
      logic               bin_empty;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_SLICE,
      ST_RD,
      ST_ACC,
      ST_MEAN,
      ST_CLEAR,
      ST_OUT
   } state_type;

endpackage

>>> rtl/binned_weighted_velocity_profile_core.sv
// A frame is handled in idle; a sample keeps the core busy for two divider passes
// (position remainder, slice index), a memory read and a write back; a readout reads
// its bin and divides for the mean, or answers without dividing for an empty bin.
// One transaction is in flight at a time; the next is taken back in idle with no
// response pending. The bit-serial divider sets the rate. After reset a clearing pass
// zeroes all MAX_GROUPS*MAX_SLICES accumulator entries; no item is taken then.
module binned_weighted_velocity_profile_core
   import bwvp_pkg::*;
#(
   parameter int MAX_SLICES = 256,
   parameter int MAX_GROUPS = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [8:0] csr_data
);
   localparam int SB = $clog2(MAX_SLICES);
   localparam int AB = $clog2(MAX_GROUPS * MAX_SLICES);
   localparam int DEPTH = MAX_GROUPS * MAX_SLICES;
   localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

   logic [63:0] vsum_mem [DEPTH];
   logic [47:0] wsum_mem [DEPTH];

   state_type st_ff, st_in;
   logic [8:0]  nreg_ff;
   logic        cmode_ff, wmass_ff;
   logic [30:0] height_ff;
   req_type     item_ff;
   logic [31:0] w_ff;
   logic [AB-1:0] addr_ff, addr_in;
   logic        phase_ff, phase_in;
   logic [63:0] rv_ff;
   logic [47:0] rw_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic        wr_en;
   logic [63:0] wr_v;
   logic [47:0] wr_w;
   logic [AB-1:0] clr_ff;
   logic        neg_ff;

   logic        dstart;
   logic [63:0] dnum, dden, dq, dr;
   logic        ddone;

   bwvp_divider #(.WIDTH(64)) u_div (
      .clock, .reset, .start(dstart), .dividend(dnum), .divisor(dden),
      .done(ddone), .quotient(dq), .remainder(dr)
   );

   logic [9:0]  n_eff;
   logic        odd_c;
   logic [31:0] z_c;
   logic signed [31:0] pos_s;
   logic [63:0] pabs;
   always_comb begin
      if (nreg_ff == 9'd0) n_eff = 10'd1;
      else if (int'(nreg_ff) > MAX_SLICES) n_eff = 10'(MAX_SLICES);
      else n_eff = {1'b0, nreg_ff};
      odd_c = cmode_ff & n_eff[0];
      pos_s = item_ff.position;
      pabs  = pos_s[31] ? 64'(-{{32{pos_s[31]}}, pos_s}) : 64'({1'b0, pos_s[30:0]});
      // Remainder is that of |position|; for a negative position wrap it into range.
      z_c = (pos_s[31] && dr[31:0] != 32'd0) ? 32'({1'b0, height_ff}) - dr[31:0] : dr[31:0];
   end

   logic signed [63:0] prod_c, vsum_c, vsum_new;
   logic [48:0] wsum_new;
   always_comb begin
      prod_c   = $signed(item_ff.velocity) * $signed({32'd0, w_ff});
      vsum_c   = $signed(rv_ff);
      vsum_new = vsum_c + prod_c;
      if (!vsum_c[63] && !prod_c[63] && vsum_new[63]) vsum_new = S64_MAX;
      if (vsum_c[63] && prod_c[63] && !vsum_new[63]) vsum_new = S64_MIN;
      wsum_new = {1'b0, rw_ff} + 49'(w_ff);
      if (wsum_new[48]) wsum_new = {1'b0, {48{1'b1}}};
   end

   always_comb begin
      st_in        = st_ff;
      addr_in      = addr_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      dstart       = 1'b0;
      dnum         = pabs;
      dden         = 64'(height_ff);
      wr_en        = 1'b0;
      wr_v         = vsum_new;
      wr_w         = wsum_new[47:0];
      req_ready    = 1'b0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (st_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            wr_v  = '0;
            wr_w  = '0;
            if (clr_ff == AB'(DEPTH - 1)) st_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = !rsp_valid_ff;
            if (req_valid && req_ready) begin
               case (kind_type'(req_data.kind))
                  KIND_SAMPLE: if (32'(req_data.group) < 32'(MAX_GROUPS)) begin
                     st_in    = ST_DIV;
                     phase_in = 1'b0;
                  end
                  KIND_READOUT: begin
                     if (32'(req_data.group) < 32'(MAX_GROUPS) &&
                         32'(req_data.bin_select) < 32'(MAX_SLICES)) begin
                        addr_in = AB'(32'(req_data.group) * MAX_SLICES +
                                      32'(req_data.bin_select));
                        st_in   = ST_RD;
                     end else begin
                        rsp_in = '{out_group: req_data.group, out_slice: req_data.bin_select,
                                   mean_velocity: '0, total_weight: '0, bin_empty: 1'b1};
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_DIV: begin
            if (!phase_ff) begin
               dstart   = 1'b1;
               phase_in = 1'b1;
            end else if (ddone) begin
               st_in    = ST_SLICE;
               phase_in = 1'b0;
            end
         end
         ST_SLICE: begin
            dstart = !phase_ff;
            if (odd_c) begin
               // Adding 2NH to the numerator keeps it positive and biases the quotient by N.
               dnum = 64'(2 * 64'(z_c) * 64'(n_eff)) + 64'(n_eff) * 64'(height_ff);
               dden = 64'(height_ff) << 1;
            end else begin
               dnum = 64'(z_c) * 64'(n_eff);
               dden = 64'(height_ff);
            end
            if (!phase_ff) phase_in = 1'b1;
            else if (ddone) begin
               phase_in = 1'b0;
               st_in    = ST_RD;
            end
         end
         ST_RD: st_in = ST_ACC;
         ST_ACC: begin
            if (kind_type'(item_ff.kind) == KIND_SAMPLE) begin
               wr_en = 1'b1;
               st_in = ST_IDLE;
            end else if (rw_ff == 48'd0) begin
               rsp_in = '{out_group: item_ff.group, out_slice: item_ff.bin_select,
                          mean_velocity: '0, total_weight: '0, bin_empty: 1'b1};
               rsp_valid_in = 1'b1;
               st_in = ST_IDLE;
            end else begin
               dnum   = rv_ff[63] ? 64'(-$signed(rv_ff)) : rv_ff;
               dden   = 64'(rw_ff);
               dstart = 1'b1;
               st_in  = ST_MEAN;
            end
         end
         ST_MEAN: if (ddone) begin
            rsp_in.out_group    = item_ff.group;
            rsp_in.out_slice    = item_ff.bin_select;
            rsp_in.total_weight = rw_ff;
            rsp_in.bin_empty    = 1'b0;
            if (!neg_ff) rsp_in.mean_velocity = (dq > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : dq[31:0];
            else rsp_in.mean_velocity = (dq > 64'h8000_0000) ? 32'h8000_0000 : 32'(-dq[31:0]);
            rsp_valid_in = 1'b1;
            st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // Slice index after the second division.
   logic [63:0] sl_raw;
   logic [SB:0] sl_fin;
   always_comb begin
      // Odd centered: num = 2zN + NH, floor(num/2H) = floor((2zN-NH)/2H) + N.
      // Then s = that - N + k; clamp at 0; reduce by N if >= N.
      if (odd_c) sl_raw = dq - 64'(n_eff) + 64'((n_eff - 10'd1) >> 1);
      else sl_raw = dq;
      if (odd_c && (dq + 64'((n_eff - 10'd1) >> 1)) < 64'(n_eff)) sl_raw = 64'd0;
      if (sl_raw >= 64'(n_eff)) sl_raw = sl_raw - 64'(n_eff);
      sl_fin = (SB+1)'(sl_raw);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_CLEAR;
         clr_ff       <= '0;
         nreg_ff      <= SLICE_COUNT_RESET;
         cmode_ff     <= 1'b0;
         wmass_ff     <= 1'b0;
         height_ff    <= HEIGHT_RESET;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         st_ff        <= st_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         if (st_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (csr_write) begin
            case (csr_index)
               CSR_SLICE_COUNT: nreg_ff  <= csr_data;
               CSR_CENTER_MODE: cmode_ff <= csr_data[0];
               CSR_WEIGHT_MASS: wmass_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (st_ff == ST_IDLE && req_valid && req_ready &&
             kind_type'(req_data.kind) == KIND_FRAME && req_data.box_height != 31'd0)
            height_ff <= req_data.box_height;
      end
      rsp_ff <= rsp_in;
      if (st_ff == ST_IDLE && req_valid && req_ready) begin
         item_ff <= req_data;
         w_ff    <= wmass_ff ? req_data.weight : ONE_Q16;
      end
      if (st_ff == ST_SLICE && phase_ff && ddone)
         addr_ff <= AB'(32'(item_ff.group) * MAX_SLICES + 32'(sl_fin));
      else
         addr_ff <= addr_in;
      if (st_ff == ST_ACC) neg_ff <= rv_ff[63];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         vsum_mem[st_ff == ST_CLEAR ? clr_ff : addr_ff] <= wr_v;
         wsum_mem[st_ff == ST_CLEAR ? clr_ff : addr_ff] <= wr_w;
      end
      rv_ff <= vsum_mem[addr_ff];
      rw_ff <= wsum_mem[addr_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

>>> rtl/bwvp_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Used for the position remainder, the slice index and the weighted mean.
// Depends on nothing.
module bwvp_divider #(
   parameter int WIDTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);
   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] quo_ff, quo_in, rem_ff, rem_in, den_ff;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [WIDTH:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[WIDTH-1]} - {1'b0, den_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CW'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[WIDTH]) begin
            rem_in = trial[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[WIDTH-2:0], quo_ff[WIDTH-1]};
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) den_ff <= divisor;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

>>> rtl/bwvp_checker.sv
// Port-level checker for the binned weighted velocity profile core.
// Depends on bwvp_pkg; bound to the top level below.
module bwvp_checker
   import bwvp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request changed while stalled");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bin_empty |-> rsp_data.mean_velocity == 32'd0 &&
      rsp_data.total_weight == 48'd0)
      else $error("empty bin with nonzero fields");
   a_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.bin_empty |-> rsp_data.total_weight != 48'd0)
      else $error("nonempty bin with zero weight");
   a_no_ready_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("accepted while result pending");
endmodule

bind binned_weighted_velocity_profile_core bwvp_checker u_bwvp_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .req_data(req_data), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);

>>> tb/binned_weighted_velocity_profile_core_tb.sv
// Self-checking testbench for binned_weighted_velocity_profile_core.
// It predicts the readout results from its own model of the bins and compares
// them with the responses. It depends on bwvp_pkg and the core RTL.
module binned_weighted_velocity_profile_core_tb
   import bwvp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLICES = 256;
   localparam int GROUPS = 4;
   localparam int SETTLE = 300;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_write = 1'b0;
   logic [1:0] csr_index = CSR_SLICE_COUNT;
   logic [8:0] csr_data = '0;

   binned_weighted_velocity_profile_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   longint      velocity_sum [0:GROUPS*SLICES-1];
   logic [47:0] mass_sum [0:GROUPS*SLICES-1];
   logic [30:0] box_height_now = HEIGHT_RESET;
   logic [8:0]  slice_count_now = SLICE_COUNT_RESET;
   logic        center_now = 1'b0;
   logic        mass_now = 1'b0;

   req_type pending_items [$];
   rsp_type expected_bins [$];
   int      mismatches = 0;
   bit      calm = 1'b0;
   int      send_gap = 0;
   int      recv_gap = 0;

   function automatic int slices_used();
      if (slice_count_now == 0) return 1;
      if (slice_count_now > SLICES) return SLICES;
      return int'(slice_count_now);
   endfunction

   function automatic int slice_of(logic signed [31:0] pos);
      longint h, n, z, s, num, den;
      h = longint'(box_height_now);
      n = longint'(slices_used());
      z = longint'(pos) % h;
      if (z < 0) z += h;
      if (center_now && n[0]) begin
         num = 2 * z * n - n * h;
         den = 2 * h;
         s = num / den;
         if ((num % den) != 0 && num < 0) s -= 1;
         s += (n - 1) / 2;
         if (s < 0) s = 0;
      end else begin
         s = z * n / h;
      end
      if (s >= n) s -= n;
      return int'(s);
   endfunction

   function automatic void predict_bins(req_type it);
      longint      w, prod, sum, mean;
      logic [48:0] wsum;
      int          bin;
      rsp_type     r;
      case (kind_type'(it.kind))
         KIND_FRAME: begin
            if (it.box_height != 0) box_height_now = it.box_height;
         end
         KIND_SAMPLE: begin
            w = mass_now ? longint'({32'd0, it.weight}) : longint'(ONE_Q16);
            bin = int'(it.group) * SLICES + slice_of(it.position);
            prod = longint'(it.velocity) * w;
            sum = velocity_sum[bin] + prod;
            if (prod > 0 && sum < velocity_sum[bin]) sum = 64'sh7FFFFFFFFFFFFFFF;
            if (prod < 0 && sum > velocity_sum[bin]) sum = 64'sh8000000000000000;
            velocity_sum[bin] = sum;
            wsum = {1'b0, mass_sum[bin]} + w[48:0];
            mass_sum[bin] = wsum[48] ? 48'hFFFFFFFFFFFF : wsum[47:0];
         end
         KIND_READOUT: begin
            bin = int'(it.group) * SLICES + int'(it.bin_select);
            r.out_group = it.group;
            r.out_slice = it.bin_select;
            r.total_weight = mass_sum[bin];
            r.bin_empty = (mass_sum[bin] == 0);
            mean = 0;
            if (!r.bin_empty) begin
               mean = velocity_sum[bin] / longint'({16'd0, mass_sum[bin]});
               if (mean > 64'sd2147483647) mean = 64'sd2147483647;
               if (mean < -64'sd2147483648) mean = -64'sd2147483648;
            end
            r.mean_velocity = mean[31:0];
            expected_bins.push_back(r);
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_bins(req_data);
         if (!(req_valid && !req_ready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               req_data <= pending_items.pop_front();
               req_valid <= 1'b1;
               if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 4);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bins.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %p", rsp_data);
            end else begin
               want = expected_bins.pop_front();
               if (rsp_data.out_group !== want.out_group
                   || rsp_data.out_slice !== want.out_slice
                   || rsp_data.mean_velocity !== want.mean_velocity
                   || rsp_data.total_weight !== want.total_weight
                   || rsp_data.bin_empty !== want.bin_empty) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p, got %p", want, rsp_data);
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm && $urandom_range(0, 4) == 0) recv_gap = $urandom_range(1, 4);
         end
      end
   end

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_items.size() > 0 || req_valid || expected_bins.size() > 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_config(logic [8:0] slices, logic center, logic by_mass);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_SLICE_COUNT;
      csr_data <= slices;
      @(posedge clock);
      csr_index <= CSR_CENTER_MODE;
      csr_data <= {8'd0, center};
      @(posedge clock);
      csr_index <= CSR_WEIGHT_MASS;
      csr_data <= {8'd0, by_mass};
      @(posedge clock);
      csr_write <= 1'b0;
      slice_count_now = slices;
      center_now = center;
      mass_now = by_mass;
   endtask

   function automatic req_type make_item(kind_type k, logic [1:0] g,
                                         logic [31:0] pos, logic [31:0] vel,
                                         logic [31:0] w, logic [30:0] h,
                                         logic [7:0] sel);
      req_type it;
      it.kind = k;
      it.group = g;
      it.position = pos;
      it.velocity = vel;
      it.weight = w;
      it.box_height = h;
      it.bin_select = sel;
      return it;
   endfunction

   function automatic logic [31:0] any_word();
      case ($urandom_range(0, 5))
         0: return 32'h80000000;
         1: return 32'h7FFFFFFF;
         2: return $urandom_range(0, 200000) - 100000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [30:0] any_height();
      case ($urandom_range(0, 4))
         0: return 31'h7FFFFFFF;
         1: return 31'($urandom_range(1, 16));
         2: return 31'($urandom_range(65536, 655360));
         default: return 31'($urandom);
      endcase
   endfunction

   initial begin
      int          sent, n, pick;
      logic [8:0]  slices;
      logic [7:0]  sel;
      logic [31:0] pos;
      for (int i = 0; i < GROUPS * SLICES; i++) begin
         velocity_sum[i] = 0;
         mass_sum[i] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      pending_items.push_back(make_item(KIND_FRAME, '0, '0, '0, '0, 31'd0, '0));
      pending_items.push_back(make_item(KIND_SAMPLE, 2'd0, 32'd0, 32'h7FFFFFFF, '0, '0, '0));
      pending_items.push_back(make_item(KIND_SAMPLE, 2'd1, 32'hFFFFFFFF, 32'h80000000,
                                        '0, '0, '0));
      pending_items.push_back(make_item(KIND_SAMPLE, 2'd2, 32'h80000000, 32'd5, '0, '0, '0));
      pending_items.push_back(make_item(KIND_SAMPLE, 2'd3, 32'h7FFFFFFF, 32'hFFFFFFFB,
                                        '0, '0, '0));
      pending_items.push_back(make_item(KIND_NONE, 2'd3, 32'd1, 32'd1, 32'd1, 31'd5, 8'd0));
      pending_items.push_back(make_item(KIND_FRAME, '0, '0, '0, '0, 31'h7FFFFFFF, '0));
      pending_items.push_back(make_item(KIND_SAMPLE, 2'd0, 32'h7FFFFFFF, 32'd65536,
                                        '0, '0, '0));
      pending_items.push_back(make_item(KIND_SAMPLE, 2'd0, 32'h80000000, 32'd3, '0, '0, '0));
      pending_items.push_back(make_item(KIND_READOUT, 2'd0, '0, '0, '0, '0, 8'd0));
      pending_items.push_back(make_item(KIND_READOUT, 2'd1, '0, '0, '0, '0, 8'd99));
      pending_items.push_back(make_item(KIND_READOUT, 2'd3, '0, '0, '0, '0, 8'd255));
      pending_items.push_back(make_item(KIND_READOUT, 2'd0, '0, '0, '0, '0, 8'd49));
      pending_items.push_back(make_item(KIND_READOUT, 2'd0, '0, '0, '0, '0, 8'd50));
      pending_items.push_back(make_item(KIND_READOUT, 2'd2, '0, '0, '0, '0, 8'd0));
      pending_items.push_back(make_item(KIND_READOUT, 2'd3, '0, '0, '0, '0, 8'd99));
      sent = 15;

      for (int phase = 0; sent < 1950; phase++) begin
         wait_drained();
         case (phase)
            0: set_config(9'd1, 1'b0, 1'b1);
            1: set_config(9'd256, 1'b1, 1'b1);
            2: set_config(9'd0, 1'b1, 1'b0);
            3: set_config(9'd511, 1'b0, 1'b0);
            4: set_config(9'd255, 1'b1, 1'b1);
            5: set_config(9'd3, 1'b1, 1'b0);
            6: set_config(9'd2, 1'b1, 1'b1);
            default: begin
               slices = ($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(1, 12));
               set_config(slices, 1'($urandom), 1'($urandom));
            end
         endcase
         if (sent > 1750) calm = 1'b1;
         pending_items.push_back(make_item(KIND_FRAME, '0, '0, '0, '0, any_height(), '0));
         sent++;
         n = $urandom_range(20, 60);
         for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            slices = slices_used() > 255 ? 9'd255 : 9'(slices_used() - 1);
            sel = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, slices));
            pos = any_word();
            if (pick < 55) begin
               pending_items.push_back(make_item(KIND_SAMPLE, 2'($urandom), pos, any_word(),
                                                 any_word(), 31'($urandom), 8'($urandom)));
               sent++;
            end else if (pick < 92) begin
               pending_items.push_back(make_item(KIND_READOUT, 2'($urandom), $urandom,
                                                 $urandom, $urandom, 31'($urandom), sel));
               sent++;
            end else if (pick < 96) begin
               pending_items.push_back(make_item(KIND_FRAME, '0, $urandom, $urandom,
                                                 $urandom, any_height(), '0));
               sent++;
            end else begin
               pending_items.push_back(make_item(KIND_NONE, 2'($urandom), $urandom,
                                                 $urandom, $urandom, 31'($urandom),
                                                 8'($urandom)));
            end
         end
      end

      wait_drained();
      if (mismatches == 0) begin
         $display("** binned_weighted_velocity_profile_core: PASSED **");
      end else begin
         $display("** binned_weighted_velocity_profile_core: FAILED **");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("** binned_weighted_velocity_profile_core: FAILED **");
      $finish;
   end

endmodule
